/* rtl/mcc_pkg.sv */
// Shared types and constants for the magnetometer calibrate/correct core.
// No dependencies; used by every module under rtl/.
package mcc_pkg;

  localparam int AXES      = 3;
  localparam int DIV_STEPS = 16;  // 32-bit quotient, two bits per cycle
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_COMMIT  = 2'd1;
  localparam logic [1:0] FUNC_CORRECT = 2'd2;

  localparam logic REG_NOISE_LIMIT = 1'b0;
  localparam logic REG_OUTPUT_GAIN = 1'b1;

  localparam logic [14:0]        RESET_LIMIT = 15'd1000;
  localparam logic [15:0]        RESET_GAIN  = 16'd1000;
  localparam logic signed [15:0] RESET_SCALE = 16'sd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN,
    S_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_SAMPLE,
    LOP_COMMIT,
    LOP_MUL,
    LOP_DIV,
    LOP_FIN,
    LOP_ZERO
  } lane_op_t;

  typedef struct packed {
    lane_op_t    op;
    logic        all_ok;
    logic [15:0] gain;
  } lane_ctrl_t;

  typedef struct packed {
    logic               in_gate;
    logic signed [15:0] res;
    logic               ovf;
    logic               dbz;
  } lane_stat_t;

endpackage

/* rtl/mcc_lane.sv */
// One axis lane: min/max envelope, commit of offset/scale, and correction
// through a multiplier and a radix-4 restoring divider. Depends on mcc_pkg.
module mcc_lane (
  input  logic                clk,
  input  logic                rst,
  input  mcc_pkg::lane_ctrl_t ctrl,
  input  logic signed [15:0]  v,
  input  logic [14:0]         noise_limit,
  output mcc_pkg::lane_stat_t stat
);
  import mcc_pkg::*;

  logic signed [15:0] vmax, vmin, offset, scale;
  logic signed [15:0] res;
  logic               ovf, dbz, neg;
  logic [31:0]        dq;
  logic [15:0]        rem;

  logic signed [16:0] v17, lim17, sum, dif, half_sum, half_dif, diff;
  logic [16:0]        diff_mag;
  logic [15:0]        dv;
  logic [16:0]        r1, r2;
  logic               ge1, ge2;
  logic [15:0]        rem1, rem2;
  logic [31:0]        dq2;

  always_comb begin
    v17      = {v[15], v};
    lim17    = signed'({2'b00, noise_limit});
    sum      = {vmax[15], vmax} + {vmin[15], vmin};
    dif      = {vmax[15], vmax} - {vmin[15], vmin};
    // halve, truncating toward zero
    half_sum = (sum + {16'd0, sum[16]}) >>> 1;
    half_dif = (dif + {16'd0, dif[16]}) >>> 1;
    diff     = v17 - {offset[15], offset};
    diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
    dv       = scale[15] ? 16'(-scale) : 16'(scale);
    // two restoring steps per cycle
    r1   = {rem, dq[31]};
    ge1  = r1 >= {1'b0, dv};
    rem1 = ge1 ? 16'(r1 - {1'b0, dv}) : r1[15:0];
    r2   = {rem1, dq[30]};
    ge2  = r2 >= {1'b0, dv};
    rem2 = ge2 ? 16'(r2 - {1'b0, dv}) : r2[15:0];
    dq2  = {dq[29:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vmax   <= '0;
      vmin   <= '0;
      offset <= '0;
      scale  <= RESET_SCALE;
    end else begin
      case (ctrl.op)
        LOP_SAMPLE: begin
          if (ctrl.all_ok) begin
            if (v > vmax) vmax <= v;
            if (v < vmin) vmin <= v;
          end
        end
        LOP_COMMIT: begin
          offset <= half_sum[15:0];
          scale  <= half_dif[15:0];
          vmax   <= '0;
          vmin   <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (ctrl.op)
      LOP_SAMPLE: begin
        res <= v;
        ovf <= 1'b0;
        dbz <= 1'b0;
      end
      LOP_COMMIT: begin
        res <= half_sum[15:0];
        ovf <= 1'b0;
        dbz <= 1'b0;
      end
      LOP_ZERO: begin
        res <= '0;
        ovf <= 1'b0;
        dbz <= 1'b0;
      end
      LOP_MUL: begin
        dq  <= 32'(diff_mag[15:0]) * 32'(ctrl.gain);
        rem <= '0;
        neg <= diff[16] ^ scale[15];
        dbz <= (scale == '0);
      end
      LOP_DIV: begin
        dq  <= dq2;
        rem <= rem2;
      end
      LOP_FIN: begin
        if (dbz) begin
          res <= '0;
          ovf <= 1'b0;
        end else if (!neg) begin
          if (dq > 32'd32767) begin
            res <= 16'sh7fff;
            ovf <= 1'b1;
          end else begin
            res <= signed'(dq[15:0]);
            ovf <= 1'b0;
          end
        end else begin
          if (dq > 32'd32768) begin
            res <= 16'sh8000;
            ovf <= 1'b1;
          end else begin
            res <= signed'(16'(-dq[15:0]));
            ovf <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign stat.in_gate = (v17 < lim17) && (v17 > -lim17);
  assign stat.res     = res;
  assign stat.ovf     = ovf;
  assign stat.dbz     = dbz;

endmodule

/* rtl/mcc_merge.sv */
// Merge stage: combines the three lane results and flags into one output
// beat held in a register until taken. Depends on mcc_pkg.
module mcc_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  mcc_pkg::lane_stat_t lane_stat [mcc_pkg::AXES],
  input  logic                acc,
  output logic                out_free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,  // out_x, out_y, out_z
  output logic [2:0]          m_tuser   // accepted, overflow, divide_by_zero
);
  import mcc_pkg::*;

  logic ovf_any, dbz_any;

  always_comb begin
    ovf_any = 1'b0;
    dbz_any = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      ovf_any = ovf_any | lane_stat[i].ovf;
      dbz_any = dbz_any | lane_stat[i].dbz;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {lane_stat[2].res, lane_stat[1].res, lane_stat[0].res};
      m_tuser <= {dbz_any, ovf_any, acc};
    end
  end

endmodule

/* rtl/magnetometer_calibrate_correct_core.sv */
// Magnetometer min/max calibration and correction, one item at a time.
// Sample, commit and unused codes pass through the execute and done states and
// the merge register; correction passes through multiply, 16 divider steps of two
// quotient bits each in every axis lane, saturate and the merge register.
// A new item is taken only once the last one's output beat is loaded, which waits
// while the previous output beat has not been taken by m_tready.
// Synchronous reset: noise_limit and gain 1000, envelopes/offsets 0, scales 1000.
module magnetometer_calibrate_correct_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_first, raw_second, raw_third
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_x, out_y, out_z
  output logic [2:0]  m_tuser,   // accepted, overflow, divide_by_zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import mcc_pkg::*;

  seq_state_t         state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [1:0]         func;
  logic signed [15:0] axis_v [AXES];
  logic               acc, acc_next;
  logic [14:0]        noise_limit;
  logic [15:0]        output_gain;
  lane_ctrl_t         ctrl;
  lane_stat_t         lane_stat [AXES];
  logic               all_ok, load, out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_limit <= RESET_LIMIT;
      output_gain <= RESET_GAIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NOISE_LIMIT: noise_limit <= cfg_data[14:0];
        REG_OUTPUT_GAIN: output_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // remap to body axes on the input beat
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func      <= s_tuser;
      axis_v[0] <= signed'(16'(-s_tdata[47:32]));
      axis_v[1] <= signed'(s_tdata[15:0]);
      axis_v[2] <= signed'(16'(-s_tdata[31:16]));
    end
  end

  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < AXES; i++) all_ok = all_ok & lane_stat[i].in_gate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      acc   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      acc   <= acc_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    acc_next    = acc;
    ctrl.op     = LOP_NONE;
    ctrl.all_ok = all_ok;
    ctrl.gain   = output_gain;
    s_tready    = 1'b0;
    load        = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        acc_next = (func == FUNC_SAMPLE) && all_ok;
        case (func)
          FUNC_SAMPLE: begin
            ctrl.op    = LOP_SAMPLE;
            state_next = S_DONE;
          end
          FUNC_COMMIT: begin
            ctrl.op    = LOP_COMMIT;
            state_next = S_DONE;
          end
          FUNC_CORRECT: begin
            ctrl.op    = LOP_MUL;
            cnt_next   = '0;
            state_next = S_DIV;
          end
          default: begin
            ctrl.op    = LOP_ZERO;
            state_next = S_DONE;
          end
        endcase
      end
      S_DIV: begin
        ctrl.op  = LOP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        ctrl.op    = LOP_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    mcc_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .v           (axis_v[g]),
      .noise_limit (noise_limit),
      .stat        (lane_stat[g])
    );
  end

  mcc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .lane_stat (lane_stat),
    .acc       (acc),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for magnetometer_calibrate_correct_core.
// Holds its own calibration/correction predictor and a scoreboard of due output beats.
// Depends on rtl/mcc_pkg.sv and rtl/magnetometer_calibrate_correct_core.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int PHASES = 6;

  typedef struct {
    logic signed [15:0] field [6];  // out_x, out_y, out_z, accepted, overflow, divide_by_zero
  } mag_beat_t;

  class calib_scoreboard;
    int errors;
    logic [14:0] noise_limit;
    logic [15:0] gain;
    int env_max [3];
    int env_min [3];
    int offset [3];
    int scale [3];
    mag_beat_t due_outputs [$];

    function new();
      errors = 0;
      noise_limit = RESET_LIMIT;
      gain = RESET_GAIN;
      for (int i = 0; i < 3; i++) begin
        env_max[i] = 0;
        env_min[i] = 0;
        offset[i] = 0;
        scale[i] = int'(RESET_SCALE);
      end
    endfunction

    function int wrap16(int v);
      logic signed [15:0] t;
      t = v[15:0];
      return int'(t);
    endfunction

    function void set_register(logic idx, logic [15:0] word);
      if (idx == REG_NOISE_LIMIT) noise_limit = word[14:0];
      else gain = word;
    endfunction

    // Advance the calibration state by one accepted input beat and queue its output.
    function void take_reading(logic [1:0] func, logic [47:0] data);
      logic signed [15:0] raw [3];
      int v [3];
      int lim;
      bit ok;
      longint diff, prod, q;
      mag_beat_t e;
      for (int i = 0; i < 3; i++) raw[i] = data[16*i +: 16];
      for (int i = 0; i < 6; i++) e.field[i] = '0;
      // body axes: x = -third, y = first, z = -second
      v[0] = wrap16(-int'(raw[2]));
      v[1] = int'(raw[0]);
      v[2] = wrap16(-int'(raw[1]));
      case (func)
        FUNC_SAMPLE: begin
          lim = int'(noise_limit);
          ok = 1'b1;
          for (int i = 0; i < 3; i++)
            if (!(v[i] < lim && v[i] > -lim)) ok = 1'b0;
          if (ok) begin
            e.field[3] = 16'sd1;
            for (int i = 0; i < 3; i++) begin
              if (v[i] > env_max[i]) env_max[i] = v[i];
              if (v[i] < env_min[i]) env_min[i] = v[i];
            end
          end
          for (int i = 0; i < 3; i++) e.field[i] = v[i][15:0];
        end
        FUNC_COMMIT: begin
          for (int i = 0; i < 3; i++) begin
            offset[i] = wrap16((env_max[i] + env_min[i]) / 2);
            scale[i] = wrap16((env_max[i] - env_min[i]) / 2);
            env_max[i] = 0;
            env_min[i] = 0;
            e.field[i] = offset[i][15:0];
          end
        end
        FUNC_CORRECT: begin
          for (int i = 0; i < 3; i++) begin
            diff = longint'(v[i]) - longint'(offset[i]);
            prod = diff * longint'(gain);
            if (scale[i] == 0) begin
              e.field[5] = 16'sd1;
            end else begin
              q = prod / longint'(scale[i]);
              if (q > 32767) begin
                q = 32767;
                e.field[4] = 16'sd1;
              end else if (q < -32768) begin
                q = -32768;
                e.field[4] = 16'sd1;
              end
              e.field[i] = q[15:0];
            end
          end
        end
        default: ;  // unused code: state untouched, all-zero output
      endcase
      due_outputs.push_back(e);
    endfunction

    function void check_output(logic [47:0] data, logic [2:0] flags);
      string names [6];
      logic signed [15:0] got;
      mag_beat_t want;
      names = '{"out_x", "out_y", "out_z", "accepted", "overflow", "divide_by_zero"};
      if (due_outputs.size() == 0) begin
        $error("output beat with no input pending: tdata %h tuser %b", data, flags);
        errors++;
        return;
      end
      want = due_outputs.pop_front();
      for (int i = 0; i < 6; i++) begin
        got = (i < 3) ? data[16*i +: 16] : {15'd0, flags[i-3]};
        if (got !== want.field[i]) begin
          $error("%s mismatch: expected %0d, actual %0d", names[i], want.field[i], got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;    // raw_first, raw_second, raw_third
  logic [1:0]  s_tuser = '0;    // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // out_x, out_y, out_z
  logic [2:0]  m_tuser;         // accepted, overflow, divide_by_zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_NOISE_LIMIT;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 21;
  int recv_idle_pct = 55;
  int work_items = 0;

  calib_scoreboard sb = new();

  magnetometer_calibrate_correct_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser);
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // tvalid stays high across back-to-back beats; it only drops when a gap is taken
  task automatic drive_item(logic [1:0] func, logic [15:0] first, logic [15:0] second,
                            logic [15:0] third);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {third, second, first};
    do @(posedge clk); while (!s_tready);
    sb.take_reading(func, {third, second, first});
    if (func != FUNC_UNUSED) work_items++;
  endtask

  task automatic write_reg(logic idx, logic [15:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, word);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.due_outputs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] any_word();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] near_word(int s);
    int v;
    v = int'($urandom_range(0, 2 * s)) - s;
    return v[15:0];
  endfunction

  // Mostly full calibrate/commit/correct rounds, with some stray beats mixed in.
  task automatic calib_round();
    int lim, span, kind, wide;
    lim = int'(sb.noise_limit);
    span = (lim > 1) ? int'($urandom_range(0, lim - 1)) : 0;
    if ($urandom_range(0, 2) == 0) span = span % 64;
    wide = (2 * span > 32767) ? 32767 : 2 * span;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(0, 7) == 0)
          drive_item(FUNC_SAMPLE, any_word(), any_word(), any_word());
        else
          drive_item(FUNC_SAMPLE, near_word(span), near_word(span), near_word(span));
      end
      drive_item(FUNC_COMMIT, any_word(), any_word(), any_word());
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1) == 0)
          drive_item(FUNC_CORRECT, near_word(wide), near_word(wide), near_word(wide));
        else
          drive_item(FUNC_CORRECT, any_word(), any_word(), any_word());
      end
    end else if (kind == 7) begin
      drive_item(FUNC_UNUSED, any_word(), any_word(), any_word());
    end else if (kind == 8) begin
      drive_item(FUNC_COMMIT, any_word(), any_word(), any_word());
    end else begin
      drive_item($urandom_range(0, 1) ? FUNC_SAMPLE : FUNC_CORRECT,
                 any_word(), any_word(), any_word());
    end
  endtask

  initial begin
    logic [15:0] limit_word, gain_word;
    int target;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: identity correction at unit gain, gate at 1000
    drive_item(FUNC_CORRECT, 16'h0000, 16'h0000, 16'h0000);
    drive_item(FUNC_CORRECT, 16'h7FFF, 16'h8000, 16'h8000);
    drive_item(FUNC_CORRECT, 16'h8000, 16'h7FFF, 16'h7FFF);
    drive_item(FUNC_SAMPLE, 16'd999, -16'sd999, 16'd0);
    drive_item(FUNC_SAMPLE, 16'd1000, 16'd0, 16'd0);        // gate edge, rejected
    drive_item(FUNC_SAMPLE, -16'sd999, 16'd999, -16'sd999);
    drive_item(FUNC_SAMPLE, 16'd0, 16'd0, -16'sd1000);      // gate edge on x
    drive_item(FUNC_SAMPLE, 16'h8000, 16'h8000, 16'h8000);  // negation wraps
    drive_item(FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_item(FUNC_SAMPLE, 16'd10, -16'sd20, 16'd30);
    drive_item(FUNC_COMMIT, 16'h0000, 16'h0000, 16'h0000);
    drive_item(FUNC_CORRECT, 16'd500, -16'sd500, 16'd700);
    drive_item(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_item(FUNC_COMMIT, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // empty envelope: zero scale
    drive_item(FUNC_CORRECT, 16'd1, 16'd2, 16'd3);
    drive_item(FUNC_SAMPLE, 16'd5, -16'sd3, 16'd2);
    drive_item(FUNC_SAMPLE, -16'sd4, 16'd6, -16'sd7);
    drive_item(FUNC_SAMPLE, 16'd0, 16'd0, 16'd5);
    drive_item(FUNC_COMMIT, 16'h1234, 16'h5678, 16'h9ABC);
    drive_item(FUNC_CORRECT, 16'h7FFF, 16'h8000, 16'd100);  // small scale saturates
    drive_item(FUNC_CORRECT, 16'h8000, 16'h7FFF, -16'sd100);
    drive_item(FUNC_CORRECT, 16'h5555, 16'hAAAA, 16'h0F0F);
    s_tvalid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin limit_word = 16'hFFFF; gain_word = 16'hFFFF; end  // widest gate, max gain
        1: begin limit_word = 16'h0000; gain_word = 16'd1;    end  // nothing passes
        2: begin limit_word = 16'd1;    gain_word = 16'd0;    end  // zero gain
        3: begin limit_word = 16'($urandom_range(2, 4000));
                 gain_word = 16'($urandom_range(1, 65535)); end
        4: begin limit_word = 16'h8000 | 16'd300; gain_word = 16'd2; end
        default: begin limit_word = any_word(); gain_word = any_word(); end
      endcase
      send_idle_pct = (p < 2) ? 21 : (p < 4) ? 55 : 0;
      recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 21 : 0;
      write_reg(REG_NOISE_LIMIT, limit_word);
      write_reg(REG_OUTPUT_GAIN, gain_word);
      target = work_items + 148;
      while (work_items < target) calib_round();
      s_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.due_outputs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
